// File: src/mtps_pkg.sv
// Shared types and constants for the MAC text partition selector.
package mtps_pkg;

    localparam int MAC_W   = 48;
    localparam int POS_W   = 5;
    localparam int CNT_W   = 6;
    localparam int PART_W  = 16;

    localparam logic [POS_W-1:0] KEY_LEN = POS_W'(17);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(31);
    localparam logic [7:0]       COLON   = 8'h3A;

    // One parsed key handed from the front end to the back end.
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic             fallback;
    } mtps_job_t;

    // Queue status seen by the top level and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } mtps_qstat_t;

endpackage

// File: src/mtps_front.sv
// Front end: parses key bytes, checks the format and builds the MAC value.
module mtps_front
    import mtps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    output logic        push,
    output mtps_job_t   push_job
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [MAC_W-1:0] acc_reg;
    logic [MAC_W-1:0] acc_next;
    logic             bad_reg;
    logic             bad_next;
    logic             is_sep;
    logic             hex_ok;
    logic [3:0]       hex_val;

    // Separator positions fall between the two-digit groups.
    assign is_sep = (pos_reg == POS_W'(2)) || (pos_reg == POS_W'(5)) ||
                    (pos_reg == POS_W'(8)) || (pos_reg == POS_W'(11)) ||
                    (pos_reg == POS_W'(14));

    // Hex digit decode, accepting 0-9, a-f and A-F only.
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (key_byte >= 8'h30 && key_byte <= 8'h39)
        begin
            hex_val = 4'(key_byte - 8'h30);
        end
        else if (key_byte >= 8'h61 && key_byte <= 8'h66)
        begin
            hex_val = 4'(key_byte - 8'h57);
        end
        else if (key_byte >= 8'h41 && key_byte <= 8'h46)
        begin
            hex_val = 4'(key_byte - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    // Next key state for the byte at hand.
    always_comb
    begin
        acc_next = acc_reg;
        bad_next = bad_reg;
        if (pos_reg >= KEY_LEN)
        begin
            bad_next = 1'b1;
        end
        else if (is_sep)
        begin
            if (key_byte != COLON)
            begin
                bad_next = 1'b1;
            end
        end
        else if (!hex_ok)
        begin
            bad_next = 1'b1;
        end
        else
        begin
            acc_next = {acc_reg[MAC_W-5:0], hex_val};
        end
        pos_next = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
    end

    // A final byte hands one job to the queue.
    assign push              = accept && key_last;
    assign push_job.mac      = acc_next;
    assign push_job.fallback = bad_next || (pos_next != KEY_LEN);

    // Key state clears after every final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            acc_reg <= '0;
            bad_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (key_last)
            begin
                pos_reg <= '0;
                acc_reg <= '0;
                bad_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                acc_reg <= acc_next;
                bad_reg <= bad_next;
            end
        end
    end

endmodule

// File: src/mtps_queue.sv
// Short job queue between the front end and the back end.
module mtps_queue
    import mtps_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  mtps_job_t   push_job,
    input  logic        pop,
    output mtps_job_t   pop_job,
    output mtps_qstat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    mtps_job_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == CNT_QW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_job    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_QW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_QW'(1);
            end
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: src/mtps_back.sv
// Back end: bit-serial 48-bit modulo and the output register.
module mtps_back
    import mtps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PART_W-1:0] partition_count,
    input  mtps_qstat_t       qstat,
    input  mtps_job_t         pop_job,
    output logic              pop,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [PART_W-1:0] partition,
    output logic              fallback
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg;
    logic [PART_W-1:0] rem_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              fb_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [PART_W-1:0] out_part_reg;
    logic              out_fb_reg;
    logic [PART_W:0]   trial;
    logic [PART_W:0]   diff;
    logic              out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == S_IDLE) && !qstat.empty;
    assign out_valid = out_valid_reg;
    assign partition = out_part_reg;
    assign fallback  = out_fb_reg;

    // One restoring step: shift in the next MAC bit, subtract if it fits.
    assign trial = {rem_reg, mac_reg[MAC_W-1]};
    assign diff  = trial - {1'b0, partition_count};

    // Output valid: cleared when the result transaction is taken, set when a new one loads.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control sequence and datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= pop_job.fallback ? S_DONE : S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(MAC_W - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    mac_reg <= pop_job.mac;
                    fb_reg  <= pop_job.fallback;
                    rem_reg <= '0;
                end
            end
            S_DIV:
            begin
                mac_reg <= {mac_reg[MAC_W-2:0], 1'b0};
                if (trial >= {1'b0, partition_count})
                begin
                    rem_reg <= diff[PART_W-1:0];
                end
                else
                begin
                    rem_reg <= trial[PART_W-1:0];
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_fb_reg   <= fb_reg;
                    out_part_reg <= (fb_reg || partition_count == '0) ? '0 : rem_reg;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

endmodule

// File: src/mac_text_partition_select.sv
// Top level of the MAC text partition selector.
// Key bytes are taken one per cycle while the job queue is not full. A malformed
// key skips the bit-serial modulo in the back end; a well formed one runs through
// it, and the back end takes no new job until its result is in the output register.
// Reset (rst_n low, asynchronous) clears the key state, the job queue and the
// output valid flag, and sets partition_count to 1.
module mac_text_partition_select
    import mtps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [PART_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        key_byte,
    input  logic              key_last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PART_W-1:0] partition,
    output logic              fallback
);

    logic [PART_W-1:0] partition_count_reg;
    logic              accept;
    logic              push;
    logic              pop;
    mtps_job_t         push_job;
    mtps_job_t         pop_job;
    mtps_qstat_t       qstat;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partition_count_reg <= PART_W'(1);
        end
        else if (cfg_write)
        begin
            partition_count_reg <= cfg_data;
        end
    end

    // Input transactions stall only while the queue is full.
    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    mtps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .key_byte (key_byte),
        .key_last (key_last),
        .push     (push),
        .push_job (push_job)
    );

    mtps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (qstat)
    );

    mtps_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .partition_count (partition_count_reg),
        .qstat           (qstat),
        .pop_job         (pop_job),
        .pop             (pop),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .partition       (partition),
        .fallback        (fallback)
    );

endmodule
